### sv/mlft_pkg.sv
// ----------------------------------------------------------------------------
// mlft_pkg
// Shared types, constants and helpers for the MAC learning forwarding table.
// ----------------------------------------------------------------------------
package mlft_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int NUM_PORTS   = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int PORT_W      = 4;
	localparam int MAC_W       = 48;
	localparam int MASK_W      = 16;
	localparam int ENTRY_W     = MAC_W + PORT_W;

	localparam int S_TDATA_W   = 104;
	localparam int S_TUSER_W   = 1;
	localparam int M_TDATA_W   = 24;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

	// Operation codes as carried in tuser.
	localparam logic OP_FRAME  = 1'b0;
	localparam logic OP_UNPLUG = 1'b1;

	typedef enum logic [1:0] {
		CMD_FRAME,
		CMD_UNPLUG,
		CMD_IGNORE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic               bcast;
		logic [PORT_W-1:0]  port;
		logic [MAC_W-1:0]   smac;
		logic [MAC_W-1:0]   dmac;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} scan_state_t;

	function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] p);
		logic [MASK_W-1:0] bit_v;
		bit_v = '0;
		if (32'(p) < NUM_PORTS && 32'(p) < MASK_W) begin
			bit_v = MASK_W'(1) << p;
		end
		return bit_v;
	endfunction

endpackage

### sv/mlft_front.sv
// ----------------------------------------------------------------------------
// mlft_front
// Input side: takes frame header and unplug transfers and classifies them
// into table commands for the command queue.
// ----------------------------------------------------------------------------
module mlft_front import mlft_pkg::*; (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // port_index, source_mac, dest_mac
	input  logic [S_TUSER_W-1:0]  s_tuser,   // operation
	input  logic                  queue_full,
	output logic                  push,
	output cmd_t                  push_cmd
);

	logic [PORT_W-1:0] port;

	assign port     = s_tdata[PORT_W-1:0];
	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	always_comb begin
		push_cmd.port  = port;
		push_cmd.smac  = s_tdata[PORT_W+MAC_W-1:PORT_W];
		push_cmd.dmac  = s_tdata[PORT_W+2*MAC_W-1:PORT_W+MAC_W];
		push_cmd.bcast = (s_tdata[PORT_W+2*MAC_W-1:PORT_W+MAC_W] == BCAST_MAC);
		// Ports beyond the configured count leave the table untouched.
		if (32'(port) >= NUM_PORTS) begin
			push_cmd.kind = CMD_IGNORE;
		end else if (s_tuser[0] == OP_UNPLUG) begin
			push_cmd.kind = CMD_UNPLUG;
		end else begin
			push_cmd.kind = CMD_FRAME;
		end
	end

endmodule

### sv/mlft_cmd_queue.sv
// ----------------------------------------------------------------------------
// mlft_cmd_queue
// Short command queue that decouples the input side from the table scanner.
// ----------------------------------------------------------------------------
module mlft_cmd_queue import mlft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### sv/mlft_back.sv
// ----------------------------------------------------------------------------
// mlft_back
// Table engine: holds the entry memory and valid bits, scans all entries
// once per frame or unplug command, learns new pairs and forms the destination port mask.
// ----------------------------------------------------------------------------
module mlft_back import mlft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata    // port_mask, is_broadcast, learned_new, table_full
);

	scan_state_t        state_q;
	scan_state_t        state_d;
	logic               out_load;

	cmd_t               cmd_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [CNT_W-1:0]   rd_cnt_q;
	logic [IDX_W-1:0]   rd_idx;
	logic               issue;

	logic               vld_s1;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic [MAC_W-1:0]   mac_s1;
	logic [PORT_W-1:0]  port_s1;

	logic               known_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [MASK_W-1:0]  mask_q;

	logic               is_frame;
	logic               learn;
	logic               full;
	logic               bcast;
	logic [MASK_W-1:0]  mask_out;

	assign rd_idx  = rd_cnt_q[IDX_W-1:0];
	assign issue   = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(TABLE_DEPTH));
	assign mac_s1  = rd_data_s1[ENTRY_W-1:PORT_W];
	assign port_s1 = rd_data_s1[PORT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (cmd.kind == CMD_IGNORE) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (vld_s1 && idx_s1 == IDX_W'(TABLE_DEPTH - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The entry just learned counts toward the mask when its MAC equals dest.
	// For broadcast it is the receiving port and is excluded, so only unicast needs it.
	always_comb begin
		is_frame = (cmd_q.kind == CMD_FRAME);
		learn    = is_frame && !known_q && free_found_q;
		full     = is_frame && !known_q && !free_found_q;
		bcast    = is_frame && cmd_q.bcast;
		mask_out = '0;
		if (is_frame) begin
			mask_out = mask_q;
			if (learn && !cmd_q.bcast && cmd_q.smac == cmd_q.dmac) begin
				mask_out = mask_q | port_bit(cmd_q.port);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
			valid_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd_pop) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			vld_s1 <= issue;
			if (vld_s1 && cmd_q.kind == CMD_UNPLUG && valid_s1 && port_s1 == cmd_q.port) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (out_load && learn) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[rd_idx];
			valid_s1   <= valid_q[rd_idx];
			idx_s1     <= rd_idx;
		end
		if (out_load && learn) begin
			mem[free_idx_q] <= {cmd_q.smac, cmd_q.port};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q        <= cmd;
			known_q      <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			mask_q       <= '0;
		end else if (vld_s1 && cmd_q.kind == CMD_FRAME) begin
			if (valid_s1) begin
				if (mac_s1 == cmd_q.smac && port_s1 == cmd_q.port) begin
					known_q <= 1'b1;
				end
				if (cmd_q.bcast) begin
					if (port_s1 != cmd_q.port) begin
						mask_q <= mask_q | port_bit(port_s1);
					end
				end else if (mac_s1 == cmd_q.dmac) begin
					mask_q <= mask_q | port_bit(port_s1);
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
		if (out_load) begin
			m_tdata <= {{(M_TDATA_W - MASK_W - 3){1'b0}}, full, learn, bcast, mask_out};
		end
	end

endmodule

### sv/mac_learning_forwarding_table_unit.sv
// ----------------------------------------------------------------------------
// mac_learning_forwarding_table_unit
// Learning bridge MAC table: learns source pairs and returns the port mask
// for each frame header; removes all entries of a port on unplug.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                          Per transfer
//  s_axis   in   tdata: port_index, source_mac, dest_mac         one command
//                tuser: operation
//  m_axis   out  tdata: port_mask, is_broadcast, learned_new,    one result
//                       table_full
//
//  A frame or unplug command is processed by a sequential scan of the entry
//  memory at one read per cycle.
//  Commands for ports beyond the port count skip the scan.
//  Reset clears every valid bit at once, so the table is empty after reset.
//  A two-entry command queue keeps taking input, until it is full, while the
//  engine scans or while a result waits in the output register for m_tready.
// ----------------------------------------------------------------------------
module mac_learning_forwarding_table_unit import mlft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // port_index[3:0], source_mac[51:4], dest_mac[99:52]
	input  logic [S_TUSER_W-1:0]  s_tuser,   // operation[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata    // port_mask[15:0], is_broadcast[16],
	                                         // learned_new[17], table_full[18]
);

	logic queue_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	mlft_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	mlft_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	mlft_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
